FILE: src/probe_ray_direction_generator_defines.svh
// ----------------------------------------------------------------------------
// Probe ray direction generator assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef PROBE_RAY_DIRECTION_GENERATOR_DEFINES_SVH
`define PROBE_RAY_DIRECTION_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define PRDG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define PRDG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/prdg_pkg.sv
// ----------------------------------------------------------------------------
// Probe ray direction generator package
// Field widths, reset values, hash constants, register indexes and a bit-reversal helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prdg_pkg;

    localparam int AXIS_MAX_DEF  = 64;
    localparam int DIR_FRAC_DEF  = 14;
    localparam int FRAC_BITS     = 24;

    localparam int RAY_W   = 16;
    localparam int FRAME_W = 32;
    localparam int PROBE_W = 32;
    localparam int DIR_W   = 16;
    localparam int RPA_W   = 7;
    localparam int AF_W    = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [RPA_W-1:0] RPA_RESET = 7'd4;
    localparam logic [AF_W-1:0]  AF_RESET  = 16'd16;

    localparam logic [31:0] HASH_K1 = 32'h9E3779B9;
    localparam logic [31:0] HASH_K2 = 32'h85EBCA6B;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAYS_PER_AXIS = 1'b0,
        CFG_ACCUM_FRAMES  = 1'b1
    } t_cfg_reg;

    function automatic logic [31:0] bit_rev32(input logic [31:0] b);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i] = b[31-i];
        end
        return r;
    endfunction

endpackage

FILE: src/prdg_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage over LANES numerators sharing one divisor.
// Requires (numerator >> Q_W) < divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prdg_div #(
    parameter int LANES  = 1,
    parameter int NUM_W  = 16,
    parameter int DEN_W  = 16,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [LANES-1:0][NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]              i_den,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [LANES-1:0][Q_W-1:0]     o_quo,
    output logic [LANES-1:0][DEN_W-1:0]   o_rem,
    output logic [SIDE_W-1:0]             o_side
);

    logic                        r_vld  [Q_W];
    logic [LANES-1:0][DEN_W-1:0] r_rem  [Q_W];
    logic [LANES-1:0][Q_W-1:0]   r_qs   [Q_W];
    logic [DEN_W-1:0]            r_den  [Q_W];
    logic [SIDE_W-1:0]           r_side [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic                        s_vld_in;
        logic [LANES-1:0][DEN_W-1:0] s_rem_in;
        logic [LANES-1:0][Q_W-1:0]   s_qs_in;
        logic [DEN_W-1:0]            s_den_in;
        logic [SIDE_W-1:0]           s_side_in;
        logic [LANES-1:0][DEN_W-1:0] n_rem;
        logic [LANES-1:0][Q_W-1:0]   n_qs;
        logic [DEN_W:0]              s_t;
        logic [DEN_W:0]              s_d;

        if (k == 0) begin : g_first
            always_comb begin
                s_vld_in  = i_valid;
                s_den_in  = i_den;
                s_side_in = i_side;
                for (int l = 0; l < LANES; l++) begin
                    s_qs_in[l]  = i_num[l][Q_W-1:0];
                    s_rem_in[l] = DEN_W'(i_num[l] >> Q_W);
                end
            end
        end else begin : g_next
            always_comb begin
                s_vld_in  = r_vld[k-1];
                s_den_in  = r_den[k-1];
                s_side_in = r_side[k-1];
                s_qs_in   = r_qs[k-1];
                s_rem_in  = r_rem[k-1];
            end
        end

        always_comb begin
            s_t = '0;
            s_d = '0;
            for (int l = 0; l < LANES; l++) begin
                s_t = {s_rem_in[l], s_qs_in[l][Q_W-1]};
                s_d = s_t - {1'b0, s_den_in};
                if (s_t >= {1'b0, s_den_in}) begin
                    n_rem[l] = s_d[DEN_W-1:0];
                    n_qs[l]  = Q_W'({s_qs_in[l], 1'b1});
                end else begin
                    n_rem[l] = s_t[DEN_W-1:0];
                    n_qs[l]  = Q_W'({s_qs_in[l], 1'b0});
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_qs[k]   <= n_qs;
                r_den[k]  <= s_den_in;
                r_side[k] <= s_side_in;
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quo   = r_qs[Q_W-1];
    assign o_rem   = r_rem[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

FILE: src/prdg_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prdg_isqrt #(
    parameter int R_W    = 25,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*R_W-1:0]  i_val,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [R_W-1:0]    o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int V_W   = 2 * R_W;
    localparam int REM_W = R_W + 2;
    localparam int A_W   = R_W + 4;

    logic              r_vld  [R_W];
    logic [REM_W-1:0]  r_rem  [R_W];
    logic [R_W-1:0]    r_root [R_W];
    logic [V_W-1:0]    r_vb   [R_W];
    logic [SIDE_W-1:0] r_side [R_W];

    for (genvar k = 0; k < R_W; k++) begin : g_stage
        logic              s_vld_in;
        logic [REM_W-1:0]  s_rem_in;
        logic [R_W-1:0]    s_root_in;
        logic [V_W-1:0]    s_vb_in;
        logic [SIDE_W-1:0] s_side_in;
        logic [A_W-1:0]    s_a;
        logic [A_W-1:0]    s_trial;
        logic              s_ge;

        if (k == 0) begin : g_first
            always_comb begin
                s_vld_in  = i_valid;
                s_rem_in  = '0;
                s_root_in = '0;
                s_vb_in   = i_val;
                s_side_in = i_side;
            end
        end else begin : g_next
            always_comb begin
                s_vld_in  = r_vld[k-1];
                s_rem_in  = r_rem[k-1];
                s_root_in = r_root[k-1];
                s_vb_in   = r_vb[k-1];
                s_side_in = r_side[k-1];
            end
        end

        assign s_a     = {s_rem_in, s_vb_in[V_W-1 -: 2]};
        assign s_trial = A_W'({s_root_in, 2'b01});
        assign s_ge    = (s_a >= s_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= s_ge ? REM_W'(s_a - s_trial) : REM_W'(s_a);
                r_root[k] <= R_W'({s_root_in, s_ge});
                r_vb[k]   <= V_W'({s_vb_in, 2'b00});
                r_side[k] <= s_side_in;
            end
        end
    end

    assign o_valid = r_vld[R_W-1];
    assign o_root  = r_root[R_W-1];
    assign o_side  = r_side[R_W-1];

endmodule

FILE: src/probe_ray_direction_generator.sv
// ----------------------------------------------------------------------------
// Probe ray direction generator
// Ray number, frame number and probe index in; one unit direction out.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carrying ray number, frame number and probe
// index; a transaction completes on a clock edge with i_valid high and o_stall
// low. Output channel: o_valid / i_stall carrying dir_x, dir_y, dir_z in
// signed Q2.14 (DIR_FRACTION_BITS fraction bits).
// Configuration channel: i_cfg_valid / o_cfg_ready with a register index and
// data; index 0 is rays per axis, index 1 is accumulation frames. Write only
// while no transaction is in flight.
// Throughput: one transaction per cycle while o_stall is low.
// Pipeline: the hash stages, the bit-per-stage dividers (frame modulo,
// Hammersley fraction, cell index, cell coordinates, octahedral u, v, output
// scaling), the decode and fold stages and the square-root stages.
// Reset clears all valid bits and loads rays per axis 4, frames 16.
// When the receiver stalls, the result holds on the output and the next one
// drops into a skid register; o_stall then freezes the whole pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module probe_ray_direction_generator #(
    parameter int AXIS_MAX          = prdg_pkg::AXIS_MAX_DEF,
    parameter int DIR_FRACTION_BITS = prdg_pkg::DIR_FRAC_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [prdg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [prdg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [prdg_pkg::RAY_W-1:0]           i_ray_number,
    input  logic [prdg_pkg::FRAME_W-1:0]         i_frame_number,
    input  logic [prdg_pkg::PROBE_W-1:0]         i_probe_index,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [prdg_pkg::DIR_W-1:0]    o_dir_x,
    output logic signed [prdg_pkg::DIR_W-1:0]    o_dir_y,
    output logic signed [prdg_pkg::DIR_W-1:0]    o_dir_z
);

    import prdg_pkg::*;

    localparam int AXIS_W = $clog2(AXIS_MAX + 1);
    localparam int CNT_W  = $clog2(AXIS_MAX * AXIS_MAX + 1);
    localparam int HY_W   = FRAC_BITS;
    localparam int N_W    = FRAC_BITS + 2;
    localparam int R_W    = FRAC_BITS + 1;
    localparam int SQ_W   = 2 * R_W;
    localparam int MAG_W  = FRAC_BITS + 1;
    localparam int OQ_W   = DIR_FRACTION_BITS + 1;
    localparam int ONUM_W = MAG_W + OQ_W + 1;
    localparam int ODEN_W = R_W + 1;
    localparam int OW     = OQ_W + DIR_W;
    localparam int PAD_W  = FRAC_BITS - 16;
    localparam int S1_W   = RAY_W + HY_W + 32;
    localparam logic signed [N_W-1:0] ONE = N_W'(1) << FRAC_BITS;

    // Configuration
    logic [RPA_W-1:0]  r_rays_per_axis;
    logic [AF_W-1:0]   r_accum_frames;
    logic [AXIS_W-1:0] r_axis;
    logic [CNT_W-1:0]  r_count;
    logic [AF_W-1:0]   r_frames;
    logic [AXIS_W-1:0] n_axis;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rays_per_axis <= RPA_RESET;
            r_accum_frames  <= AF_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_RAYS_PER_AXIS: r_rays_per_axis <= i_cfg_data[RPA_W-1:0];
                CFG_ACCUM_FRAMES:  r_accum_frames  <= i_cfg_data[AF_W-1:0];
            endcase
        end
    end

    always_comb begin
        if (r_rays_per_axis == '0) begin
            n_axis = AXIS_W'(1);
        end else if (32'(r_rays_per_axis) > AXIS_MAX) begin
            n_axis = AXIS_W'(AXIS_MAX);
        end else begin
            n_axis = AXIS_W'(r_rays_per_axis);
        end
    end

    always_ff @(posedge i_clk) begin
        r_axis   <= n_axis;
        r_count  <= CNT_W'(r_axis) * CNT_W'(r_axis);
        r_frames <= (r_accum_frames == '0) ? AF_W'(1) : r_accum_frames;
    end

    // Output register and skid stage
    logic r_out_valid;
    logic r_skid_valid;
    logic w_en;

    assign w_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // Hash stages
    logic              r_s0_vld, r_s1_vld, r_s2_vld;
    logic [RAY_W-1:0]  r_s0_ray, r_s1_ray, r_s2_ray;
    logic [31:0]       r_s0_frame, r_s1_frame, r_s2_frame;
    logic [HY_W-1:0]   r_s0_hy, r_s1_hy, r_s2_hy;
    logic [31:0]       r_s0_m, r_s1_m, r_s2_h;
    logic [31:0]       w_rev;
    logic [31:0]       w_m1x;

    assign w_rev = bit_rev32(i_frame_number);
    assign w_m1x = r_s0_m ^ (r_s0_m >> 15);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_valid;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_ray   <= i_ray_number;
            r_s0_frame <= i_frame_number;
            r_s0_hy    <= w_rev[31 -: HY_W];
            r_s0_m     <= i_probe_index * HASH_K1;
            r_s1_ray   <= r_s0_ray;
            r_s1_frame <= r_s0_frame;
            r_s1_hy    <= r_s0_hy;
            r_s1_m     <= w_m1x * HASH_K2;
            r_s2_ray   <= r_s1_ray;
            r_s2_frame <= r_s1_frame;
            r_s2_hy    <= r_s1_hy;
            r_s2_h     <= r_s1_m ^ (r_s1_m >> 13);
        end
    end

    // Frame modulo frame count
    logic              w_d1_vld;
    logic [AF_W-1:0]   w_d1_rem [1];
    logic [S1_W-1:0]   w_d1_side;

    prdg_div #(
        .LANES(1), .NUM_W(32), .DEN_W(AF_W), .Q_W(32), .SIDE_W(S1_W)
    ) u_div_fmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_vld),
        .i_num   (r_s2_frame),
        .i_den   (r_frames),
        .i_side  ({r_s2_ray, r_s2_hy, r_s2_h}),
        .o_valid (w_d1_vld),
        .o_quo   (),
        .o_rem   (w_d1_rem[0]),
        .o_side  (w_d1_side)
    );

    // Hammersley fraction
    logic              w_d2_vld;
    logic [FRAC_BITS-1:0] w_hx;
    logic [S1_W-1:0]   w_d2_side;

    prdg_div #(
        .LANES(1), .NUM_W(AF_W + FRAC_BITS), .DEN_W(AF_W), .Q_W(FRAC_BITS),
        .SIDE_W(S1_W)
    ) u_div_hfrac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d1_vld),
        .i_num   ({w_d1_rem[0], {FRAC_BITS{1'b0}}}),
        .i_den   (r_frames),
        .i_side  (w_d1_side),
        .o_valid (w_d2_vld),
        .o_quo   (w_hx),
        .o_rem   (),
        .o_side  (w_d2_side)
    );

    logic [RAY_W-1:0]     w_d2_ray;
    logic [HY_W-1:0]      w_d2_hy;
    logic [31:0]          w_d2_h;
    logic [FRAC_BITS-1:0] w_wx, w_wy;

    assign {w_d2_ray, w_d2_hy, w_d2_h} = w_d2_side;
    assign w_wx = w_hx    + {w_d2_h[15:0],  {PAD_W{1'b0}}};
    assign w_wy = w_d2_hy + {w_d2_h[31:16], {PAD_W{1'b0}}};

    // Cell index
    logic                     w_d3_vld;
    logic [CNT_W-1:0]         w_idx;
    logic [2*FRAC_BITS-1:0]   w_d3_side;

    prdg_div #(
        .LANES(1), .NUM_W(RAY_W), .DEN_W(CNT_W), .Q_W(RAY_W),
        .SIDE_W(2 * FRAC_BITS)
    ) u_div_cell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d2_vld),
        .i_num   (w_d2_ray),
        .i_den   (r_count),
        .i_side  ({w_wx, w_wy}),
        .o_valid (w_d3_vld),
        .o_quo   (),
        .o_rem   (w_idx),
        .o_side  (w_d3_side)
    );

    // Cell coordinates
    logic                   w_d4_vld;
    logic [CNT_W-1:0]       w_cy;
    logic [AXIS_W-1:0]      w_cx;
    logic [2*FRAC_BITS-1:0] w_d4_side;

    prdg_div #(
        .LANES(1), .NUM_W(CNT_W), .DEN_W(AXIS_W), .Q_W(CNT_W),
        .SIDE_W(2 * FRAC_BITS)
    ) u_div_coord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d3_vld),
        .i_num   (w_idx),
        .i_den   (r_axis),
        .i_side  (w_d3_side),
        .o_valid (w_d4_vld),
        .o_quo   (w_cy),
        .o_rem   (w_cx),
        .o_side  (w_d4_side)
    );

    // Octahedral coordinates u, v
    logic                                    w_d5_vld;
    logic [1:0][AXIS_W+FRAC_BITS-1:0]        w_uv_num;
    logic [1:0][FRAC_BITS-1:0]               w_uv;

    assign w_uv_num[0] = {w_cx, w_d4_side[2*FRAC_BITS-1:FRAC_BITS]};
    assign w_uv_num[1] = {w_cy[AXIS_W-1:0], w_d4_side[FRAC_BITS-1:0]};

    prdg_div #(
        .LANES(2), .NUM_W(AXIS_W + FRAC_BITS), .DEN_W(AXIS_W), .Q_W(FRAC_BITS),
        .SIDE_W(1)
    ) u_div_uv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d4_vld),
        .i_num   (w_uv_num),
        .i_den   (r_axis),
        .i_side  (1'b0),
        .o_valid (w_d5_vld),
        .o_quo   (w_uv),
        .o_rem   (),
        .o_side  ()
    );

    // Decode and fold
    logic                  r_f1_vld, r_f2_vld, r_f3_vld, r_f4_vld;
    logic signed [N_W-1:0] r_f1_nx, r_f1_ny, r_f1_ax, r_f1_ay;
    logic signed [N_W-1:0] r_f2_x, r_f2_y, r_f2_z;
    logic signed [N_W-1:0] r_f3_x, r_f3_y, r_f3_z;
    logic signed [N_W-1:0] r_f4_x, r_f4_y, r_f4_z;
    logic [SQ_W-1:0]       r_f3_sx, r_f3_sy, r_f3_sz;
    logic [SQ_W-1:0]       r_f4_sum;
    logic signed [N_W-1:0] w_nx, w_ny, w_nz, w_fold;
    logic signed [2*N_W-1:0] w_px, w_py, w_pz;

    assign w_nx   = $signed({1'b0, w_uv[0], 1'b0}) - ONE;
    assign w_ny   = $signed({1'b0, w_uv[1], 1'b0}) - ONE;
    assign w_nz   = ONE - r_f1_ax - r_f1_ay;
    assign w_fold = w_nz[N_W-1] ? -w_nz : '0;
    assign w_px   = r_f2_x * r_f2_x;
    assign w_py   = r_f2_y * r_f2_y;
    assign w_pz   = r_f2_z * r_f2_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
            r_f4_vld <= 1'b0;
        end else if (w_en) begin
            r_f1_vld <= w_d5_vld;
            r_f2_vld <= r_f1_vld;
            r_f3_vld <= r_f2_vld;
            r_f4_vld <= r_f3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_nx  <= w_nx;
            r_f1_ny  <= w_ny;
            r_f1_ax  <= w_nx[N_W-1] ? -w_nx : w_nx;
            r_f1_ay  <= w_ny[N_W-1] ? -w_ny : w_ny;
            r_f2_x   <= r_f1_nx[N_W-1] ? r_f1_nx + w_fold : r_f1_nx - w_fold;
            r_f2_y   <= r_f1_ny[N_W-1] ? r_f1_ny + w_fold : r_f1_ny - w_fold;
            r_f2_z   <= w_nz;
            r_f3_x   <= r_f2_x;
            r_f3_y   <= r_f2_y;
            r_f3_z   <= r_f2_z;
            r_f3_sx  <= w_px[SQ_W-1:0];
            r_f3_sy  <= w_py[SQ_W-1:0];
            r_f3_sz  <= w_pz[SQ_W-1:0];
            r_f4_x   <= r_f3_x;
            r_f4_y   <= r_f3_y;
            r_f4_z   <= r_f3_z;
            r_f4_sum <= r_f3_sx + r_f3_sy + r_f3_sz;
        end
    end

    // Length
    logic                w_sq_vld;
    logic [R_W-1:0]      w_root;
    logic [3*N_W-1:0]    w_sq_side;

    prdg_isqrt #(
        .R_W(R_W), .SIDE_W(3 * N_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_f4_vld),
        .i_val   (r_f4_sum),
        .i_side  ({r_f4_x, r_f4_y, r_f4_z}),
        .o_valid (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // Scale set-up
    logic signed [N_W-1:0]      w_sx, w_sy, w_sz;
    logic [R_W-1:0]             w_len;
    logic [2:0][MAG_W-1:0]      w_mag;
    logic                       r_f5_vld;
    logic [2:0][ONUM_W-1:0]     r_f5_num;
    logic [ODEN_W-1:0]          r_f5_den;
    logic [2:0]                 r_f5_neg;

    assign {w_sx, w_sy, w_sz} = w_sq_side;
    assign w_len    = (w_root == '0) ? R_W'(1) : w_root;
    assign w_mag[2] = w_sx[N_W-1] ? MAG_W'(-w_sx) : MAG_W'(w_sx);
    assign w_mag[1] = w_sy[N_W-1] ? MAG_W'(-w_sy) : MAG_W'(w_sy);
    assign w_mag[0] = w_sz[N_W-1] ? MAG_W'(-w_sz) : MAG_W'(w_sz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f5_vld <= 1'b0;
        end else if (w_en) begin
            r_f5_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_f5_num[l] <= (ONUM_W'(w_mag[l]) << OQ_W) + ONUM_W'(w_len);
            end
            r_f5_den <= {w_len, 1'b0};
            r_f5_neg <= {w_sx[N_W-1], w_sy[N_W-1], w_sz[N_W-1]};
        end
    end

    // Output scaling, rounded to nearest
    logic                   w_do_vld;
    logic [2:0][OQ_W-1:0]   w_q;
    logic [2:0]             w_do_neg;
    logic [2:0][OW-1:0]     w_sgn;
    logic                   w_fire;

    prdg_div #(
        .LANES(3), .NUM_W(ONUM_W), .DEN_W(ODEN_W), .Q_W(OQ_W), .SIDE_W(3)
    ) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_f5_vld),
        .i_num   (r_f5_num),
        .i_den   (r_f5_den),
        .i_side  (r_f5_neg),
        .o_valid (w_do_vld),
        .o_quo   (w_q),
        .o_rem   (),
        .o_side  (w_do_neg)
    );

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_sgn[l] = w_do_neg[l] ? (OW'(0) - OW'(w_q[l])) : OW'(w_q[l]);
        end
    end

    assign w_fire = w_do_vld && w_en;

    logic signed [DIR_W-1:0] r_out_x, r_out_y, r_out_z;
    logic signed [DIR_W-1:0] r_skid_x, r_skid_y, r_skid_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_fire;
            end
        end else if (w_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_x <= r_skid_x;
                r_out_y <= r_skid_y;
                r_out_z <= r_skid_z;
            end else begin
                r_out_x <= w_sgn[2][DIR_W-1:0];
                r_out_y <= w_sgn[1][DIR_W-1:0];
                r_out_z <= w_sgn[0][DIR_W-1:0];
            end
        end else if (w_fire) begin
            r_skid_x <= w_sgn[2][DIR_W-1:0];
            r_skid_y <= w_sgn[1][DIR_W-1:0];
            r_skid_z <= w_sgn[0][DIR_W-1:0];
        end
    end

    assign o_valid = r_out_valid;
    assign o_dir_x = r_out_x;
    assign o_dir_y = r_out_y;
    assign o_dir_z = r_out_z;

endmodule

FILE: src/prdg_chk.sv
// ----------------------------------------------------------------------------
// Probe ray direction generator port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "probe_ray_direction_generator_defines.svh"

module prdg_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [prdg_pkg::DIR_W-1:0] o_dir_x,
    input logic signed [prdg_pkg::DIR_W-1:0] o_dir_y,
    input logic signed [prdg_pkg::DIR_W-1:0] o_dir_z
);

    // Back-pressure only while a result is waiting
    `PRDG_ASSERT_NOW(a_stall_needs_out, i_clk, i_rst_n, o_stall, o_valid, "stall without result")

    // A direction is never the null vector
    `PRDG_ASSERT_NOW(a_dir_nonzero, i_clk, i_rst_n, o_valid, o_dir_x != 0 || o_dir_y != 0 || o_dir_z != 0, "null direction")

    // Nothing emerges on the first cycle out of reset
    `PRDG_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, !$past(i_rst_n), !o_valid && !o_stall, "output after reset")

    // Held result stays put
    `PRDG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_dir_x) && $stable(o_dir_y) && $stable(o_dir_z), "stalled result changed")

endmodule

bind probe_ray_direction_generator prdg_chk u_prdg_chk (.*);
